// File: hdl/rvss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvss_pkg;

    localparam int XLEN     = 32;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);

    // major opcodes
    localparam logic [6:0] OP_REG    = 7'd51;
    localparam logic [6:0] OP_IMM    = 7'd19;
    localparam logic [6:0] OP_LOAD   = 7'd3;
    localparam logic [6:0] OP_JALR   = 7'd103;
    localparam logic [6:0] OP_STORE  = 7'd35;
    localparam logic [6:0] OP_BRANCH = 7'd99;
    localparam logic [6:0] OP_LUI    = 7'd55;
    localparam logic [6:0] OP_AUIPC  = 7'd23;
    localparam logic [6:0] OP_JAL    = 7'd111;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_WORD = 3'd2;  // widest supported load/store size
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_JALR = 3'd0;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_MEM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              wr;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   val;
        logic [1:0]        status;
    } t_exec_res;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

endpackage

`default_nettype wire

// File: hdl/rv32i_subset_core_step.sv
`timescale 1ns / 1ps
`default_nettype none

// RV32I subset core step: each input word is one 32-bit instruction taken to
// sit at the core's current PC (zero after reset); each output word reports
// that PC, the next PC, the write-back (x0 writes are suppressed) and a
// status: executed, memory access not performed (loads/stores only report
// their effective address), or unsupported encoding (no-op, PC + 4). One
// instruction is taken per clock while the result side keeps up, and every
// instruction yields exactly one result. The accept edge reads both
// register-file ports into the decode stage; the execute edge, once the
// output register is free or being drained, writes the register file and PC
// and loads the output register. The rate is set by that register-file write
// landing on the same edge as the next instruction's read, which a bypass
// covers. The output register decouples the sides, so a new word is taken
// into an empty decode stage while an earlier result still waits. The
// register file and PC reset to zero at once; no clearing pass is needed.
module rv32i_subset_core_step import rvss_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // instruction channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_instr_word,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [XLEN-1:0]    o_instr_pc,
    output logic      [XLEN-1:0]    o_next_pc,
    output logic                    o_reg_write,
    output logic      [REG_AW-1:0]  o_dest_index,
    output logic signed [XLEN-1:0]  o_value_out,
    output logic      [1:0]         o_status
);

    // decode stage
    logic            r_s1_valid;
    logic [31:0]     r_instr;
    logic            w_in_fire;
    logic            w_exec_fire;

    // architectural state
    logic [XLEN-1:0] r_pc;

    // output register
    logic            r_out_valid;
    t_exec_res       r_out;
    logic [XLEN-1:0] r_out_pc;

    logic [XLEN-1:0] w_a, w_b;
    t_exec_res       w_res;
    t_rf_wr          w_rf_wr;

    // execute when an instruction is held and the output slot is free or
    // being drained this cycle
    assign w_exec_fire = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_exec_fire;
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign w_rf_wr.en   = w_exec_fire && w_res.wr;
    assign w_rf_wr.addr = w_res.rd;
    assign w_rf_wr.data = w_res.val;

    rvss_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_fire),
        .i_rs1      (i_instr_word[19:15]),
        .i_rs2      (i_instr_word[24:20]),
        .i_wr       (w_rf_wr),
        .o_rs1_data (w_a),
        .o_rs2_data (w_b)
    );

    rvss_exec u_exec (
        .i_instr (r_instr),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_pc    (r_pc),
        .o_res   (w_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_exec_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_exec_fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= w_res.next_pc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_instr <= i_instr_word;
        end
        if (w_exec_fire) begin
            r_out    <= w_res;
            r_out_pc <= r_pc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_instr_pc   = r_out_pc;
    assign o_next_pc    = r_out.next_pc;
    assign o_reg_write  = r_out.wr;
    assign o_dest_index = r_out.rd;
    assign o_value_out  = $signed(r_out.val);
    assign o_status     = r_out.status;

    // the shown result's next PC is always where the core now stands
    a_pc_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_next_pc == r_pc))
        else $error("result next_pc differs from core pc");

    // a write-back is only reported for executed ops with a real destination
    a_wr_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reg_write) |-> ((o_dest_index != '0) && (o_status == ST_OK)))
        else $error("illegal write-back reported");

    // unsupported encodings act as no-ops
    a_bad_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_BAD)) |->
            ((o_value_out == '0) && (o_next_pc == o_instr_pc + 32'd4) && !o_reg_write))
        else $error("unsupported encoding not a no-op");

    // an empty decode stage never stalls the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled with empty decode stage");

    // an execute step always leaves a result in the output register
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_fire |=> o_out_valid)
        else $error("executed instruction produced no result");

endmodule

`default_nettype wire

// File: hdl/rvss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rvss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/rvss_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

// Two read ports = two RAM copies written together. Per-entry valid bits
// give the all-zero reset; a same-edge write to a read address is bypassed.
module rvss_regfile import rvss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [REG_AW-1:0] i_rs1,
    input  wire logic [REG_AW-1:0] i_rs2,
    input  wire t_rf_wr            i_wr,
    output logic      [XLEN-1:0]   o_rs1_data,
    output logic      [XLEN-1:0]   o_rs2_data
);

    logic [NUM_REGS-1:0] r_valid;
    logic                r_byp1, r_byp2;
    logic                r_ok1, r_ok2;
    logic [XLEN-1:0]     r_byp_data;
    logic [XLEN-1:0]     w_q1, w_q2;
    logic                w_hit1, w_hit2;

    assign w_hit1 = i_wr.en && (i_wr.addr == i_rs1);
    assign w_hit2 = i_wr.en && (i_wr.addr == i_rs2);

    rvss_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rs1),
        .o_rdata (w_q1)
    );

    rvss_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram2 (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rs2),
        .o_rdata (w_q2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_byp1  <= 1'b0;
            r_byp2  <= 1'b0;
            r_ok1   <= 1'b0;
            r_ok2   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_byp1 <= w_hit1;
                r_byp2 <= w_hit2;
                r_ok1  <= r_valid[i_rs1];
                r_ok2  <= r_valid[i_rs2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rs1_data = r_byp1 ? r_byp_data : (r_ok1 ? w_q1 : '0);
    assign o_rs2_data = r_byp2 ? r_byp_data : (r_ok2 ? w_q2 : '0);

endmodule

`default_nettype wire

// File: hdl/rvss_exec.sv
`timescale 1ns / 1ps
`default_nettype none

// Decode, immediates, ALU, branch compare and next-PC select.
module rvss_exec import rvss_pkg::*; (
    input  wire logic [31:0]   i_instr,
    input  wire logic [XLEN-1:0] i_a,
    input  wire logic [XLEN-1:0] i_b,
    input  wire logic [XLEN-1:0] i_pc,
    output t_exec_res          o_res
);

    logic [6:0]      w_op;
    logic [2:0]      w_f3;
    logic [6:0]      w_f7;
    logic [4:0]      w_shamt;
    logic [XLEN-1:0] w_seq;
    logic [XLEN-1:0] w_imm_i, w_imm_s, w_imm_b, w_imm_u, w_imm_j;
    logic            w_lt;
    logic            w_take;
    logic            w_ok;
    logic            w_wr;
    logic [XLEN-1:0] w_val;
    logic [XLEN-1:0] w_next;
    logic [1:0]      w_status;

    assign w_op    = i_instr[6:0];
    assign w_f3    = i_instr[14:12];
    assign w_f7    = i_instr[31:25];
    assign w_shamt = i_b[4:0];
    assign w_seq   = i_pc + 32'd4;
    assign w_lt    = $signed(i_a) < $signed(i_b);

    assign w_imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign w_imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign w_imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                      i_instr[11:8], 1'b0};
    assign w_imm_u = {i_instr[31:12], 12'd0};
    assign w_imm_j = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                      i_instr[30:21], 1'b0};

    always_comb begin
        w_ok     = 1'b1;
        w_wr     = 1'b0;
        w_val    = '0;
        w_next   = w_seq;
        w_status = ST_OK;
        w_take   = 1'b0;
        unique case (w_op)
            OP_REG: begin
                w_wr = 1'b1;
                if (w_f7 == F7_BASE) begin
                    unique case (w_f3)
                        F3_ADD:  w_val = i_a + i_b;
                        F3_SLL:  w_val = i_a << w_shamt;
                        F3_SLT:  w_val = {{(XLEN-1){1'b0}}, w_lt};
                        F3_XOR:  w_val = i_a ^ i_b;
                        F3_SR:   w_val = i_a >> w_shamt;
                        F3_OR:   w_val = i_a | i_b;
                        F3_AND:  w_val = i_a & i_b;
                        default: w_ok = 1'b0;
                    endcase
                end else if (w_f7 == F7_ALT) begin
                    unique case (w_f3)
                        F3_ADD:  w_val = i_a - i_b;
                        F3_SR:   w_val = $unsigned($signed(i_a) >>> w_shamt);
                        default: w_ok = 1'b0;
                    endcase
                end else begin
                    w_ok = 1'b0;
                end
            end
            OP_IMM: begin
                w_wr = 1'b1;
                unique case (w_f3)
                    F3_ADD:  w_val = i_a + w_imm_i;
                    F3_AND:  w_val = i_a & w_imm_i;
                    F3_OR:   w_val = i_a | w_imm_i;
                    default: w_ok = 1'b0;
                endcase
            end
            OP_LOAD: begin
                w_val    = i_a + w_imm_i;
                w_status = ST_MEM;
                w_ok     = (w_f3 <= F3_WORD);
            end
            OP_STORE: begin
                w_val    = i_a + w_imm_s;
                w_status = ST_MEM;
                w_ok     = (w_f3 <= F3_WORD);
            end
            OP_JALR: begin
                w_val  = w_seq;
                w_next = (i_a + w_imm_i) & ~32'd1;
                w_wr   = 1'b1;
                w_ok   = (w_f3 == F3_JALR);
            end
            OP_BRANCH: begin
                unique case (w_f3)
                    F3_BEQ:  w_take = (i_a == i_b);
                    F3_BNE:  w_take = (i_a != i_b);
                    F3_BLT:  w_take = w_lt;
                    F3_BGE:  w_take = !w_lt;
                    default: w_ok = 1'b0;
                endcase
                if (w_take) begin
                    w_next = i_pc + w_imm_b;
                end
            end
            OP_LUI: begin
                w_val = w_imm_u;
                w_wr  = 1'b1;
            end
            OP_AUIPC: begin
                w_val = i_pc + w_imm_u;
                w_wr  = 1'b1;
            end
            OP_JAL: begin
                w_val  = w_seq;
                w_next = i_pc + w_imm_j;
                w_wr   = 1'b1;
            end
            default: w_ok = 1'b0;
        endcase
        if (!w_ok) begin
            w_val    = '0;
            w_wr     = 1'b0;
            w_status = ST_BAD;
            w_next   = w_seq;
        end
    end

    assign o_res.next_pc = w_next;
    assign o_res.rd      = i_instr[11:7];
    assign o_res.wr      = w_wr && (i_instr[11:7] != '0);
    assign o_res.val     = w_val;
    assign o_res.status  = w_status;

endmodule

`default_nettype wire
